// ===== rtl/pge_pkg.sv =====
// ----------------------------------------------------------------------------
// pge_pkg
// Shared constants, types and arithmetic helpers of the product graph edge
// test: store geometry, field widths, command codes and square-root steps.
// ----------------------------------------------------------------------------
package pge_pkg;

  localparam int ATOM_SLOTS   = 1024;
  localparam int VERTEX_SLOTS = 4096;
  localparam int COORD_BITS   = 19;

  localparam int ATOM_AW   = $clog2(ATOM_SLOTS);
  localparam int VTX_AW    = $clog2(VERTEX_SLOTS);
  localparam int SLOT_W    = 12;
  localparam int NO_W      = 11;
  localparam int RES_W     = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int REM_W     = ROOT_W + 4;
  localparam int ISQ_STAGES = 5;
  localparam int ISQ_PER    = (ROOT_W + ISQ_STAGES - 1) / ISQ_STAGES;
  localparam int ISQ_PAIRS  = ISQ_STAGES * ISQ_PER;
  localparam int ISQ_RAD_W  = 2 * ISQ_PAIRS;

  typedef enum logic [1:0] {
    CMD_LOAD_TGT = 2'd0,
    CMD_LOAD_QRY = 2'd1,
    CMD_LOAD_VTX = 2'd2,
    CMD_TEST     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL = 2'd0,
    CFG_MIN = 2'd1,
    CFG_MAX = 2'd2,
    CFG_RES = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RES_W-1:0]      res;
    logic [COORD_BITS-1:0] z;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } atom_t;

  typedef struct packed {
    logic [ATOM_AW-1:0] qidx;
    logic [ATOM_AW-1:0] tidx;
  } vtx_t;

  typedef struct packed {
    logic               valid;
    logic               is_test;
    logic [ATOM_AW-1:0] qa;
    logic [ATOM_AW-1:0] qb;
    logic [ATOM_AW-1:0] ta;
    logic [ATOM_AW-1:0] tb;
    logic               same_res;
  } tag_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } isq_t;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic [COORD_BITS-1:0] ua;
    logic [COORD_BITS-1:0] ub;
    ua = {~a[COORD_BITS-1], a[COORD_BITS-2:0]};
    ub = {~b[COORD_BITS-1], b[COORD_BITS-2:0]};
    return (ua > ub) ? ua - ub : ub - ua;
  endfunction

  // one restoring root bit from the next radicand bit pair
  function automatic isq_t isqrt_step(input isq_t s, input logic [1:0] pair);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    isq_t             o;
    rem_sh = {s.rem[REM_W-3:0], pair};
    trial  = {2'b00, s.root, 2'b01};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/pge_in_if.sv =====
// ----------------------------------------------------------------------------
// pge_in_if
// Request channel of the edge test: command, slot, atom and vertex fields.
// ----------------------------------------------------------------------------
interface pge_in_if;
  import pge_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [SLOT_W-1:0]            slot;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic [RES_W-1:0]             residue_id;
  logic [NO_W-1:0]              query_atom_no;
  logic [NO_W-1:0]              target_atom_no;
  logic [SLOT_W-1:0]            first_vertex;
  logic [SLOT_W-1:0]            second_vertex;

  modport source (
    output valid, cmd, slot, coord_x, coord_y, coord_z, residue_id,
           query_atom_no, target_atom_no, first_vertex, second_vertex,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, coord_x, coord_y, coord_z, residue_id,
           query_atom_no, target_atom_no, first_vertex, second_vertex,
    output ready
  );
endinterface

// ===== rtl/pge_out_if.sv =====
// ----------------------------------------------------------------------------
// pge_out_if
// Result channel of the edge test: edge flag and the four atom numbers.
// ----------------------------------------------------------------------------
interface pge_out_if;
  import pge_pkg::*;

  logic            valid;
  logic            ready;
  logic            is_edge;
  logic [NO_W-1:0] target_first;
  logic [NO_W-1:0] target_second;
  logic [NO_W-1:0] query_first;
  logic [NO_W-1:0] query_second;

  modport source (
    output valid, is_edge, target_first, target_second, query_first, query_second,
    input  ready
  );
  modport sink (
    input  valid, is_edge, target_first, target_second, query_first, query_second,
    output ready
  );
endinterface

// ===== rtl/pge_isqrt.sv =====
// ----------------------------------------------------------------------------
// pge_isqrt
// Pipelined exact integer square root of two radicands side by side, four
// root bits per stage, with a request tag traveling alongside.
// ----------------------------------------------------------------------------
module pge_isqrt
  import pge_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tag_t              tag_in,
  input  logic [SUM_W-1:0]  rad_q,
  input  logic [SUM_W-1:0]  rad_t,
  output tag_t              tag_out,
  output logic [ROOT_W-1:0] root_q,
  output logic [ROOT_W-1:0] root_t
);

  tag_t                 tag_r   [ISQ_STAGES];
  isq_t                 q_r     [ISQ_STAGES];
  isq_t                 t_r     [ISQ_STAGES];
  logic [ISQ_RAD_W-1:0] radq_r  [ISQ_STAGES];
  logic [ISQ_RAD_W-1:0] radt_r  [ISQ_STAGES];

  isq_t                 q_nxt    [ISQ_STAGES];
  isq_t                 t_nxt    [ISQ_STAGES];
  logic [ISQ_RAD_W-1:0] radq_nxt [ISQ_STAGES];
  logic [ISQ_RAD_W-1:0] radt_nxt [ISQ_STAGES];

  always_comb begin
    isq_t                 cq;
    isq_t                 ct;
    logic [ISQ_RAD_W-1:0] rq;
    logic [ISQ_RAD_W-1:0] rt;
    for (int s = 0; s < ISQ_STAGES; s++) begin
      if (s == 0) begin
        cq = '0;
        ct = '0;
        rq = ISQ_RAD_W'(rad_q);
        rt = ISQ_RAD_W'(rad_t);
      end else begin
        cq = q_r[(s == 0) ? 0 : s - 1];
        ct = t_r[(s == 0) ? 0 : s - 1];
        rq = radq_r[(s == 0) ? 0 : s - 1];
        rt = radt_r[(s == 0) ? 0 : s - 1];
      end
      for (int j = 0; j < ISQ_PER; j++) begin
        cq = isqrt_step(cq, rq[ISQ_RAD_W-1-2*j -: 2]);
        ct = isqrt_step(ct, rt[ISQ_RAD_W-1-2*j -: 2]);
      end
      q_nxt[s]    = cq;
      t_nxt[s]    = ct;
      radq_nxt[s] = rq << (2 * ISQ_PER);
      radt_nxt[s] = rt << (2 * ISQ_PER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ISQ_STAGES; s++) begin
        tag_r[s] <= '0;
      end
    end else if (en) begin
      tag_r[0] <= tag_in;
      for (int s = 1; s < ISQ_STAGES; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ISQ_STAGES; s++) begin
        q_r[s]    <= q_nxt[s];
        t_r[s]    <= t_nxt[s];
        radq_r[s] <= radq_nxt[s];
        radt_r[s] <= radt_nxt[s];
      end
    end
  end

  assign tag_out = tag_r[ISQ_STAGES-1];
  assign root_q  = q_r[ISQ_STAGES-1].root;
  assign root_t  = t_r[ISQ_STAGES-1].root;

endmodule

// ===== rtl/product_graph_edge_test.sv =====
// ----------------------------------------------------------------------------
// product_graph_edge_test
// Stores target and query atoms and a vertex table, and tests vertex pairs
// for distance compatibility.
//
// in_ch carries requests: target atom load, query atom load, vertex load and
// pair test. Every request gives exactly one result on out_ch, in order; loads
// answer with all fields zero. Requests are taken one per cycle while out_ch
// is not stalled. A request passes through these registered stages in order:
// vertex table read, atom store read, coordinate differences, squares, sum,
// five square-root stages, final compare into the output register.
// The stores are block memories written when a load is taken; a test reads
// the vertex table then the atom stores, so later loads never affect it.
// The whole pipeline advances together: when out_ch is stalled with a result
// waiting, in_ch.ready drops and every stage holds.
// Reset clears the pipeline valid bits and loads the configuration defaults;
// store contents are undefined until loaded, with no clearing pass.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle;
// the block itself does not enforce this.
module product_graph_edge_test
  import pge_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pge_in_if.sink               in_ch,
  pge_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // configuration
  logic [CFG_W-1:0] tol_r;
  logic [CFG_W-1:0] min_r;
  logic [CFG_W-1:0] max_r;
  logic             resf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= CFG_W'(512);
      min_r  <= '0;
      max_r  <= '1;
      resf_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TOL: tol_r  <= cfg_wdata;
        CFG_MIN: min_r  <= cfg_wdata;
        CFG_MAX: max_r  <= cfg_wdata;
        CFG_RES: resf_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic accept;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;

  // stores
  atom_t tgt_mem [ATOM_SLOTS];
  atom_t qry_mem [ATOM_SLOTS];
  vtx_t  vtx_mem [VERTEX_SLOTS];

  logic [NO_W-1:0] qno_m1;
  logic [NO_W-1:0] tno_m1;
  atom_t           atom_wr;
  logic            atom_slot_ok;
  logic            vtx_slot_ok;

  assign qno_m1       = in_ch.query_atom_no - NO_W'(1);
  assign tno_m1       = in_ch.target_atom_no - NO_W'(1);
  assign atom_wr      = '{res: in_ch.residue_id, z: in_ch.coord_z,
                          y: in_ch.coord_y, x: in_ch.coord_x};
  assign atom_slot_ok = 32'(in_ch.slot) < ATOM_SLOTS;
  assign vtx_slot_ok  = 32'(in_ch.slot) < VERTEX_SLOTS;

  always_ff @(posedge clk) begin
    if (accept && cmd_t'(in_ch.cmd) == CMD_LOAD_TGT && atom_slot_ok) begin
      tgt_mem[in_ch.slot[ATOM_AW-1:0]] <= atom_wr;
    end
    if (accept && cmd_t'(in_ch.cmd) == CMD_LOAD_QRY && atom_slot_ok) begin
      qry_mem[in_ch.slot[ATOM_AW-1:0]] <= atom_wr;
    end
    if (accept && cmd_t'(in_ch.cmd) == CMD_LOAD_VTX && vtx_slot_ok) begin
      vtx_mem[in_ch.slot[VTX_AW-1:0]] <= '{qidx: qno_m1[ATOM_AW-1:0],
                                          tidx: tno_m1[ATOM_AW-1:0]};
    end
  end

  // vertex table read
  vtx_t vtx_a_r;
  vtx_t vtx_b_r;
  logic s1_v_r;
  logic s1_test_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vtx_a_r <= vtx_mem[in_ch.first_vertex[VTX_AW-1:0]];
      vtx_b_r <= vtx_mem[in_ch.second_vertex[VTX_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_test_r <= 1'b0;
    end else if (en) begin
      s1_v_r    <= accept;
      s1_test_r <= accept && cmd_t'(in_ch.cmd) == CMD_TEST;
    end
  end

  // atom store read
  atom_t tgt_a_r;
  atom_t tgt_b_r;
  atom_t qry_a_r;
  atom_t qry_b_r;
  tag_t  s2_tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tgt_a_r <= tgt_mem[vtx_a_r.tidx];
      tgt_b_r <= tgt_mem[vtx_b_r.tidx];
      qry_a_r <= qry_mem[vtx_a_r.qidx];
      qry_b_r <= qry_mem[vtx_b_r.qidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r <= '0;
    end else if (en) begin
      s2_tag_r <= '{valid: s1_v_r, is_test: s1_test_r,
                    qa: vtx_a_r.qidx, qb: vtx_b_r.qidx,
                    ta: vtx_a_r.tidx, tb: vtx_b_r.tidx, same_res: 1'b0};
    end
  end

  // coordinate differences
  logic [COORD_BITS-1:0] dq_r [3];
  logic [COORD_BITS-1:0] dt_r [3];
  tag_t                  s3_tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dq_r[0] <= abs_diff(qry_a_r.x, qry_b_r.x);
      dq_r[1] <= abs_diff(qry_a_r.y, qry_b_r.y);
      dq_r[2] <= abs_diff(qry_a_r.z, qry_b_r.z);
      dt_r[0] <= abs_diff(tgt_a_r.x, tgt_b_r.x);
      dt_r[1] <= abs_diff(tgt_a_r.y, tgt_b_r.y);
      dt_r[2] <= abs_diff(tgt_a_r.z, tgt_b_r.z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r <= '0;
    end else if (en) begin
      s3_tag_r <= '{valid: s2_tag_r.valid, is_test: s2_tag_r.is_test,
                    qa: s2_tag_r.qa, qb: s2_tag_r.qb,
                    ta: s2_tag_r.ta, tb: s2_tag_r.tb,
                    same_res: (qry_a_r.res == qry_b_r.res) ||
                              (tgt_a_r.res == tgt_b_r.res)};
    end
  end

  // squares
  logic [SQ_W-1:0] sq_q_r [3];
  logic [SQ_W-1:0] sq_t_r [3];
  tag_t            s4_tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_q_r[k] <= SQ_W'(dq_r[k]) * SQ_W'(dq_r[k]);
        sq_t_r[k] <= SQ_W'(dt_r[k]) * SQ_W'(dt_r[k]);
      end
    end
  end

  // sums
  logic [SUM_W-1:0] sum_q_r;
  logic [SUM_W-1:0] sum_t_r;
  tag_t             s5_tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q_r <= SUM_W'(sq_q_r[0]) + SUM_W'(sq_q_r[1]) + SUM_W'(sq_q_r[2]);
      sum_t_r <= SUM_W'(sq_t_r[0]) + SUM_W'(sq_t_r[1]) + SUM_W'(sq_t_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_tag_r <= '0;
      s5_tag_r <= '0;
    end else if (en) begin
      s4_tag_r <= s3_tag_r;
      s5_tag_r <= s4_tag_r;
    end
  end

  // square roots
  tag_t              rt_tag;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W-1:0] root_t;

  pge_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (s5_tag_r),
    .rad_q   (sum_q_r),
    .rad_t   (sum_t_r),
    .tag_out (rt_tag),
    .root_q  (root_q),
    .root_t  (root_t)
  );

  // final compare and result register
  logic [ROOT_W-1:0] delta;
  logic              edge_ok;

  assign delta   = (root_q > root_t) ? root_q - root_t : root_t - root_q;
  assign edge_ok = rt_tag.is_test &&
                   CFG_W'(delta) <= tol_r &&
                   CFG_W'(root_q) >= min_r && CFG_W'(root_t) >= min_r &&
                   CFG_W'(root_q) <= max_r && CFG_W'(root_t) <= max_r &&
                   !(resf_r && rt_tag.same_res);

  logic            out_edge_r;
  logic [NO_W-1:0] out_tf_r;
  logic [NO_W-1:0] out_ts_r;
  logic [NO_W-1:0] out_qf_r;
  logic [NO_W-1:0] out_qs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rt_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_edge_r <= edge_ok;
      out_tf_r   <= rt_tag.is_test ? NO_W'(rt_tag.ta) + NO_W'(1) : '0;
      out_ts_r   <= rt_tag.is_test ? NO_W'(rt_tag.tb) + NO_W'(1) : '0;
      out_qf_r   <= rt_tag.is_test ? NO_W'(rt_tag.qa) + NO_W'(1) : '0;
      out_qs_r   <= rt_tag.is_test ? NO_W'(rt_tag.qb) + NO_W'(1) : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.is_edge       = out_edge_r;
  assign out_ch.target_first  = out_tf_r;
  assign out_ch.target_second = out_ts_r;
  assign out_ch.query_first   = out_qf_r;
  assign out_ch.query_second  = out_qs_r;

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted request missing from first stage");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s2_tag_r) && $stable(s5_tag_r))
    else $error("pipeline moved during stall");

  a_edge_numbers : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_edge_r |-> out_tf_r != '0 && out_qs_r != '0)
    else $error("edge reported without atom numbers");

endmodule
